FILE: design/v3r_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3r_pkg
// Shared widths, limits and types for the 3D refraction pipeline.
// ----------------------------------------------------------------------------
package v3r_pkg;

  // Fixed field widths of the request and result channels.
  localparam int IN_W  = 16;
  localparam int OUT_W = 18;

  // One minus cos squared is held to this many bits, floored at -2^OM_FLOOR_EXP.
  localparam int OM_W         = 40;
  localparam int OM_FLOOR_EXP = 38;

  // Saturation limits of a result component.
  localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sh20000;

  // Result of one component lane.
  typedef struct packed {
    logic signed [OUT_W-1:0] comp;
    logic                    sat;
  } lane_out_t;

  function automatic int imax(input int a, input int b);
    imax = (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

FILE: design/v3r_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3r_sqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module v3r_sqrt
  import v3r_pkg::*;
#(
  parameter int WIDTH = 58
) (
  input  wire logic                 clk,
  input  wire logic [WIDTH-1:0]     radicand,
  output logic      [WIDTH/2-1:0]   root
);

  localparam int H = WIDTH / 2;

  logic [H+1:0]     rem_r  [0:H-1];
  logic [H-1:0]     root_r [0:H-1];
  logic [WIDTH-1:0] rad_r  [0:H-1];

  genvar j;
  generate
    for (j = 0; j < H; j++) begin : g_stage
      logic [H+1:0]     rem_in;
      logic [H-1:0]     root_in;
      logic [WIDTH-1:0] rad_in;
      logic [H+2:0]     cur;
      logic [H+2:0]     trial;
      logic             take;

      if (j == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign rad_in  = radicand;
      end else begin : g_next
        assign rem_in  = rem_r[j-1];
        assign root_in = root_r[j-1];
        assign rad_in  = rad_r[j-1];
      end

      // Bring down two radicand bits and try to subtract 4*root + 1.
      always_comb begin
        cur   = {rem_in[H:0], rad_in[WIDTH-1 -: 2]};
        trial = {1'b0, root_in, 2'b01};
        take  = (cur >= trial);
      end

      always_ff @(posedge clk) begin
        rem_r[j]  <= take ? (H+2)'(cur - trial) : cur[H+1:0];
        root_r[j] <= {root_in[H-2:0], take};
        rad_r[j]  <= rad_in << 2;
      end
    end
  endgenerate

  assign root = root_r[H-1];

endmodule
`default_nettype wire

FILE: design/v3r_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3r_lane
// One component lane: eta*I - g*N, rounded, clamped to the result range.
// ----------------------------------------------------------------------------
module v3r_lane
  import v3r_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  parameter int GW        = 40
) (
  input  wire logic                   clk,
  input  wire logic        [IN_W-1:0] eta,
  input  wire logic signed [IN_W-1:0] inc,
  input  wire logic signed [IN_W-1:0] nrm,
  input  wire logic signed [GW-1:0]   g,
  output lane_out_t                   res
);

  localparam int EIW  = 2 * IN_W + 1;
  localparam int GNW  = GW + IN_W;
  localparam int RW   = imax(EIW, GNW) + 1;
  localparam int HALF = 1 << (FRAC_BITS - 1);

  logic signed [EIW-1:0] ei_r;
  logic signed [GNW-1:0] gn_r;
  logic signed [RW-1:0]  diff;
  logic signed [RW-1:0]  rsh;

  // Both products are registered before the difference.
  always_ff @(posedge clk) begin
    ei_r <= $signed({1'b0, eta}) * inc;
    gn_r <= g * nrm;
  end

  // Round half up, then clamp to the result width.
  always_comb begin
    diff = RW'(ei_r) - RW'(gn_r);
    rsh  = (diff + $signed(RW'(HALF))) >>> FRAC_BITS;
    if (rsh > RW'(OUT_MAX)) begin
      res.comp = OUT_MAX;
      res.sat  = 1'b1;
    end else if (rsh < RW'(OUT_MIN)) begin
      res.comp = OUT_MIN;
      res.sat  = 1'b1;
    end else begin
      res.comp = rsh[OUT_W-1:0];
      res.sat  = 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: design/vector3_refract.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_refract
// Refracts an incident vector at a surface with normal N and index ratio eta.
// ----------------------------------------------------------------------------
// Usage:
//   A request is accepted on a rising edge with start high; busy is always
//   low, so a new request may be issued every cycle. Inputs are Q1.14 signed
//   incident and normal components and an unsigned Q2.14 ratio.
//   Each result appears on the out_ ports for one cycle with out_valid high.
//   Results come back in request order. The square-root radicand has an even
//   width, 58 bits at 14 fraction bits. Throughput is one request per cycle.
//   The latency is set by the square-root pipeline, which resolves one root
//   bit per stage; the dot product, cos and k terms take six stages ahead
//   of it and the component lanes plus output register three after it.
//   When k is negative the result is a zero vector with out_total_internal.
//   Reset clears only the valid pipeline; there is no stored state.
//   The receiver cannot stall; results must be taken when presented.
// ----------------------------------------------------------------------------
module vector3_refract
  import v3r_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [IN_W-1:0]  in_incident_x,
  input  wire logic signed [IN_W-1:0]  in_incident_y,
  input  wire logic signed [IN_W-1:0]  in_incident_z,
  input  wire logic signed [IN_W-1:0]  in_normal_x,
  input  wire logic signed [IN_W-1:0]  in_normal_y,
  input  wire logic signed [IN_W-1:0]  in_normal_z,
  input  wire logic        [IN_W-1:0]  in_refraction_ratio,
  output logic                         out_valid,
  output logic signed [OUT_W-1:0]      out_refracted_x,
  output logic signed [OUT_W-1:0]      out_refracted_y,
  output logic signed [OUT_W-1:0]      out_refracted_z,
  output logic                         out_total_internal,
  output logic                         out_saturated
);

  localparam int F    = FRAC_BITS;
  localparam int HALF = 1 << (F - 1);
  localparam int PRW  = 2 * IN_W;
  localparam int DW   = PRW + 1;
  localparam int CW   = 34 - F;
  localparam int CCW  = 2 * CW;
  localparam int XW   = imax(imax(2 * F + 2, CCW + 1), OM_W + 1);
  localparam int E2W  = 33 - F;
  localparam int ECPW = IN_W + 1 + CW;
  localparam int ECW  = ECPW - F + 1;
  localparam int PW   = E2W + 1 + OM_W;
  localparam int KFW  = imax(PW + 1, 2 * F + 2);
  localparam int KW   = ((imax(2 * F, 70 - F) + 2) / 2) * 2;
  localparam int H    = KW / 2;
  localparam int GW   = imax(ECW, H + 1) + 1;
  localparam int BW   = 7 * IN_W;
  localparam int NB   = 7 + H;
  localparam int NV   = 8 + H;
  localparam int NT   = 3 + H;
  localparam int NE   = 3 + H;

  localparam logic [XW-1:0]  ONE2_X = XW'(1) << (2 * F);
  localparam logic [KFW-1:0] ONE2_K = KFW'(1) << (2 * F);
  localparam logic [XW-1:0]  OMF_X  = ~((XW'(1) << OM_FLOOR_EXP) - XW'(1));

  // Valid pipeline and carried request fields.
  logic          vld_r [0:NV-1];
  logic [BW-1:0] bd_r  [0:NB-1];

  // Arithmetic stage registers.
  logic signed [PRW-1:0]  prod_r [0:2];
  logic        [PRW-1:0]  ee_r;
  logic signed [CW-1:0]   c2_r;
  logic        [E2W-1:0]  e2_r [0:2];
  logic signed [CCW-1:0]  cc3_r;
  logic signed [ECPW-1:0] ec3_r;
  logic signed [OM_W-1:0] om4_r;
  logic signed [ECW-1:0]  ec_r [0:NE-1];
  logic signed [PW-1:0]   p5_r;
  logic signed [KFW-1:0]  k6_r;
  logic                   tir_r [0:NT-1];
  logic signed [GW-1:0]   g_r;

  logic [IN_W-1:0] req_fields [0:6];
  logic [H-1:0]    sqrt_root;
  lane_out_t       lane_res [0:2];

  logic signed [DW:0]    dsum;
  logic        [PRW:0]   eesum;
  logic signed [XW-1:0]  omx;
  logic signed [ECPW:0]  ecx;
  logic signed [GW-1:0]  g_nxt;

  logic signed [OUT_W-1:0] out_x_r, out_y_r, out_z_r;
  logic                    out_valid_r, out_tir_r, out_sat_r;

  assign busy = 1'b0;

  assign req_fields[0] = in_incident_x;
  assign req_fields[1] = in_incident_y;
  assign req_fields[2] = in_incident_z;
  assign req_fields[3] = in_normal_x;
  assign req_fields[4] = in_normal_y;
  assign req_fields[5] = in_normal_z;
  assign req_fields[6] = in_refraction_ratio;

  // Valid pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NV; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= start;
      for (int i = 1; i < NV; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[NV-1];
    end
  end

  // Request fields ride along to the component lanes.
  always_ff @(posedge clk) begin
    bd_r[0] <= {in_refraction_ratio, in_normal_z, in_normal_y, in_normal_x,
                in_incident_z, in_incident_y, in_incident_x};
    for (int i = 1; i < NB; i++) bd_r[i] <= bd_r[i-1];
  end

  // Stage 1: per-axis dot product terms, one multiplier per lane, and eta^2.
  genvar a;
  generate
    for (a = 0; a < 3; a++) begin : g_dot
      always_ff @(posedge clk) begin
        prod_r[a] <= $signed(req_fields[a]) * $signed(req_fields[a+3]);
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    ee_r <= in_refraction_ratio * in_refraction_ratio;
  end

  // Stage 2: merge the lane terms into cos, round eta^2.
  always_comb begin
    dsum  = (DW+1)'(prod_r[0]) + (DW+1)'(prod_r[1]) + (DW+1)'(prod_r[2])
          + $signed((DW+1)'(HALF));
    eesum = (PRW+1)'(ee_r) + (PRW+1)'(HALF);
  end

  always_ff @(posedge clk) begin
    c2_r    <= CW'(dsum >>> F);
    e2_r[0] <= E2W'(eesum >> F);
    e2_r[1] <= e2_r[0];
    e2_r[2] <= e2_r[1];
  end

  // Stage 3: cos squared and eta*cos.
  always_ff @(posedge clk) begin
    cc3_r <= c2_r * c2_r;
    ec3_r <= $signed({1'b0, bd_r[1][6*IN_W +: IN_W]}) * c2_r;
  end

  // Stage 4: one minus cos squared with its floor, and rounded eta*cos.
  always_comb begin
    omx = ($signed(ONE2_X) - XW'(cc3_r) + $signed(XW'(HALF))) >>> F;
    if (omx < $signed(OMF_X)) omx = $signed(OMF_X);
    ecx = ((ECPW+1)'(ec3_r) + $signed((ECPW+1)'(HALF))) >>> F;
  end

  always_ff @(posedge clk) begin
    om4_r    <= OM_W'(omx);
    ec_r[0]  <= ECW'(ecx);
    for (int i = 1; i < NE; i++) ec_r[i] <= ec_r[i-1];
  end

  // Stage 5: eta^2 times one minus cos squared.
  always_ff @(posedge clk) begin
    p5_r <= $signed({1'b0, e2_r[2]}) * om4_r;
  end

  // Stage 6: k and the total internal reflection flag.
  always_ff @(posedge clk) begin
    k6_r     <= $signed(ONE2_K) - KFW'(p5_r);
    tir_r[0] <= ($signed(ONE2_K) - KFW'(p5_r)) < 0;
    for (int i = 1; i < NT; i++) tir_r[i] <= tir_r[i-1];
  end

  v3r_sqrt #(
    .WIDTH (KW)
  ) u_sqrt (
    .clk      (clk),
    .radicand (k6_r[KW-1:0]),
    .root     (sqrt_root)
  );

  // Normal scale g = eta*cos + sqrt(k).
  always_comb begin
    g_nxt = GW'(ec_r[NE-1]) + $signed(GW'(sqrt_root));
  end

  always_ff @(posedge clk) begin
    g_r <= g_nxt;
  end

  // Component lanes.
  generate
    for (a = 0; a < 3; a++) begin : g_lane
      v3r_lane #(
        .FRAC_BITS (F),
        .GW        (GW)
      ) u_lane (
        .clk (clk),
        .eta (bd_r[NB-1][6*IN_W +: IN_W]),
        .inc ($signed(bd_r[NB-1][a*IN_W +: IN_W])),
        .nrm ($signed(bd_r[NB-1][(a+3)*IN_W +: IN_W])),
        .g   (g_r),
        .res (lane_res[a])
      );
    end
  endgenerate

  // Output register: merge lane flags, zero the vector on total reflection.
  always_ff @(posedge clk) begin
    if (tir_r[NT-1]) begin
      out_x_r   <= '0;
      out_y_r   <= '0;
      out_z_r   <= '0;
      out_sat_r <= 1'b0;
    end else begin
      out_x_r   <= lane_res[0].comp;
      out_y_r   <= lane_res[1].comp;
      out_z_r   <= lane_res[2].comp;
      out_sat_r <= lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
    end
    out_tir_r <= tir_r[NT-1];
  end

  assign out_valid          = out_valid_r;
  assign out_refracted_x    = out_x_r;
  assign out_refracted_y    = out_y_r;
  assign out_refracted_z    = out_z_r;
  assign out_total_internal = out_tir_r;
  assign out_saturated      = out_sat_r;

  // Total reflection gives a zero vector and never a clamp.
  a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_total_internal |->
      out_refracted_x == '0 && out_refracted_y == '0 &&
      out_refracted_z == '0 && !out_saturated)
    else $error("total reflection result is not a clean zero vector");

  // A clamp flag means some component sits at a limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_refracted_x == OUT_MAX || out_refracted_x == OUT_MIN ||
      out_refracted_y == OUT_MAX || out_refracted_y == OUT_MIN ||
      out_refracted_z == OUT_MAX || out_refracted_z == OUT_MIN)
    else $error("saturation flag without a clamped component");

  // The last pipeline stage is presented in the next cycle.
  a_vld_out: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NV-1] |=> out_valid)
    else $error("pipeline request lost before the output");

endmodule
`default_nettype wire

FILE: verif/vector3_refract_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_refract_test
// Drives directed and random incident/normal/ratio requests into the
// refraction pipeline, predicts each result in 64-bit fixed point and checks
// every returned component and flag in request order.
// ----------------------------------------------------------------------------

// Holds predicted refraction results and compares returned ones against them.
class refract_scoreboard;
  typedef struct {
    logic signed [17:0] rx, ry, rz;
    logic               tir, sat;
  } refract_t;

  refract_t pending[$];
  int errors;
  int checked;
  int tir_seen;
  int sat_seen;

  // Round half toward plus infinity after a right shift by 14.
  static function longint round14(longint v);
    return (v + (64'sd1 <<< 13)) >>> 14;
  endfunction

  static function longint root_floor(longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'sd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Notes an accepted request by computing its expected result.
  function void note_request(logic signed [15:0] ix, iy, iz, nx, ny, nz,
                             logic [15:0] ratio);
    longint iv[3], nv[3], eta, dot, cosv, om, e2, k, g, r, one2;
    refract_t res;
    iv[0] = ix; iv[1] = iy; iv[2] = iz;
    nv[0] = nx; nv[1] = ny; nv[2] = nz;
    eta = ratio;
    one2 = 64'sd1 <<< 28;
    dot = iv[0] * nv[0] + iv[1] * nv[1] + iv[2] * nv[2];
    cosv = round14(dot);
    om = round14(one2 - cosv * cosv);
    if (om < -(64'sd1 <<< 38)) om = -(64'sd1 <<< 38);
    e2 = round14(eta * eta);
    k = one2 - e2 * om;
    res.sat = 1'b0;
    res.tir = 1'b0;
    res.rx = '0; res.ry = '0; res.rz = '0;
    if (k < 0) begin
      res.tir = 1'b1;
    end else begin
      g = round14(eta * cosv) + root_floor(k);
      for (int i = 0; i < 3; i++) begin
        r = round14(eta * iv[i] - g * nv[i]);
        if (r > 131071) begin r = 131071; res.sat = 1'b1; end
        if (r < -131072) begin r = -131072; res.sat = 1'b1; end
        if (i == 0) res.rx = r[17:0];
        else if (i == 1) res.ry = r[17:0];
        else res.rz = r[17:0];
      end
    end
    pending.push_back(res);
  endfunction

  function void report(string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endfunction

  // Compares one returned result with the oldest prediction.
  function void check_result(logic signed [17:0] rx, ry, rz, logic tir, sat);
    refract_t e;
    checked++;
    if (pending.size() == 0) begin
      report("result with no request outstanding");
      return;
    end
    e = pending.pop_front();
    if (tir) tir_seen++;
    if (sat) sat_seen++;
    if (rx !== e.rx) report($sformatf("x got %0d want %0d", rx, e.rx));
    if (ry !== e.ry) report($sformatf("y got %0d want %0d", ry, e.ry));
    if (rz !== e.rz) report($sformatf("z got %0d want %0d", rz, e.rz));
    if (tir !== e.tir) report($sformatf("total_internal got %b want %b", tir, e.tir));
    if (sat !== e.sat) report($sformatf("saturated got %b want %b", sat, e.sat));
  endfunction
endclass

module vector3_refract_test;
  import v3r_pkg::*;

  localparam int LATENCY = 38;
  localparam int RANDOM_REQUESTS = 1750;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [IN_W-1:0] in_incident_x = '0, in_incident_y = '0, in_incident_z = '0;
  logic signed [IN_W-1:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic [IN_W-1:0] in_refraction_ratio = '0;
  logic out_valid;
  logic signed [OUT_W-1:0] out_refracted_x, out_refracted_y, out_refracted_z;
  logic out_total_internal, out_saturated;

  refract_scoreboard board = new();
  int sent;

  vector3_refract dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sample results and accepted requests at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_result(out_refracted_x, out_refracted_y, out_refracted_z,
                         out_total_internal, out_saturated);
    if (rst_n && start && !busy)
      board.note_request(in_incident_x, in_incident_y, in_incident_z,
                         in_normal_x, in_normal_y, in_normal_z,
                         in_refraction_ratio);
  end

  function automatic logic [15:0] rand_gap();
    if ($urandom_range(0, 99) < 45) return 0;
    if ($urandom_range(0, 99) < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 50);
  endfunction

  // Presents one request, holds it until accepted, then idles for the given gap.
  task automatic send_request(logic [15:0] ix, iy, iz, nx, ny, nz, ratio,
                              int gap);
    in_incident_x <= ix; in_incident_y <= iy; in_incident_z <= iz;
    in_normal_x <= nx; in_normal_y <= ny; in_normal_z <= nz;
    in_refraction_ratio <= ratio;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Random unit-ish vector component near a scale of 1.0 in Q1.14.
  function automatic logic [15:0] unit_comp();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic random_phase(bit bursts);
    logic [15:0] v[7];
    int gap;
    for (int n = 0; n < RANDOM_REQUESTS / 2; n++) begin
      case ($urandom_range(0, 3))
        0: foreach (v[i]) v[i] = 16'($urandom);
        default: begin
          for (int i = 0; i < 6; i++) v[i] = unit_comp();
          v[6] = 16'($urandom_range(8000, 26000));
        end
      endcase
      if ($urandom_range(0, 9) == 0) v[6] = 16'($urandom);
      gap = bursts ? ($urandom_range(0, 99) < 95 ? 0 : rand_gap()) : rand_gap();
      send_request(v[0], v[1], v[2], v[3], v[4], v[5], v[6], gap);
    end
  endtask

  initial begin
    int waited;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, normal incidence, grazing, ratio extremes.
    send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
    send_request(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h4000, 16'h4000, 0);
    send_request(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h8000, 1);
    send_request(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 16'h0000, 16'h4000, 16'h6000, 0);
    send_request(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 16'h0000, 16'h4000, 16'h3000, 2);
    send_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 0);
    send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 0);
    send_request(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 0);
    send_request(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 3);
    send_request(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 0);
    send_request(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'h4000, 0);
    send_request(16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 5);
    send_request(16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h8000, 0);
    send_request(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA, 0);
    send_request(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555, 0);

    random_phase(1'b0);
    random_phase(1'b1);
    start <= 1'b0;

    // Drain the pipeline, then wait out any stray results.
    waited = 0;
    while (board.pending.size() != 0 && waited < 10 * LATENCY) begin
      @(negedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(negedge clk);
    if (board.pending.size() != 0)
      board.report($sformatf("%0d results never arrived", board.pending.size()));

    $display("Sent %0d requests, checked %0d results (%0d total internal, %0d saturated).",
             sent, board.checked, board.tir_seen, board.sat_seen);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
